@@ hdl/indexed_list_store_assert.svh @@
// Assertion macros used by the indexed list store RTL.
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// cond must never hold out of reset
`define ILS_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

// same-cycle implication
`define ILS_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ILS_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/ils_pkg.sv @@
// Types, sizes and codes of the indexed list store.
package ils_pkg;

    localparam int DEPTH       = 64;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int POS_W       = 10;
    localparam int ACT_W       = 3;
    localparam int STAT_W      = 2;
    localparam int COUNT_OUT_W = 11;

    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [COUNT_OUT_W-1:0]   wide_t;
    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [STAT_W-1:0]        status_t;

    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_RANGE = 2'd1;
    localparam status_t STAT_FULL  = 2'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND   = 3'd0,
        ACT_INSERT   = 3'd1,
        ACT_REM_LAST = 3'd2,
        ACT_REM_AT   = 3'd3,
        ACT_READ     = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_TAKE,
        S_LOAD,
        S_DRAIN,
        S_PUT,
        S_DONE
    } state_t;

endpackage

@@ hdl/ils_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
module ils_ram #(
    parameter int AW = 6,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/indexed_list_store.sv @@
// Indexed list store: sequencer and datapath around the element RAM.
//
// Holds an ordered list of up to DEPTH signed 32-bit values in one RAM with a single
// write port and a registered read port. Each item is one request and gives one result
// (value, status, new length). Append and insert at the end go through S_PUT; read and
// remove-last through S_TAKE and S_LOAD; insert at position p below the length through
// S_SHIFT_UP, S_DRAIN and S_PUT; remove at position p with elements after it through
// S_TAKE, S_LOAD, S_SHIFT_DN and S_DRAIN; error cases go straight to S_DONE. S_DONE
// loads the result register once the output is free, and the next item is taken in
// S_IDLE after it. The shift loop moves one element per cycle through the RAM's single
// write port. The input is stalled while a request is in progress; a finished result
// waits in the output register while the next item is taken.
`include "indexed_list_store_assert.svh"

module indexed_list_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ils_pkg::ACT_W-1:0]  action,
    input  logic [ils_pkg::POS_W-1:0]  position,
    input  logic signed [ils_pkg::DATA_W-1:0] value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [ils_pkg::DATA_W-1:0] read_value,
    output logic [ils_pkg::STAT_W-1:0] status,
    output logic [ils_pkg::COUNT_OUT_W-1:0] count_after
);

    import ils_pkg::*;

    state_t  state_reg, state_next;
    action_t op_reg, op_next;
    addr_t   pos_reg, pos_next;
    addr_t   rd_reg, rd_next;
    addr_t   lim_reg, lim_next;
    data_t   val_reg, val_next;
    data_t   rv_reg, rv_next;
    status_t stat_reg, stat_next;
    cnt_t    count_reg, count_next;
    logic    wpend_reg, wpend_next;
    addr_t   wpaddr_reg, wpaddr_next;

    logic    out_valid_reg, out_valid_next;
    data_t   rv_out_reg, rv_out_next;
    status_t stat_out_reg, stat_out_next;
    cnt_t    cnt_out_reg, cnt_out_next;

    logic    in_fire;
    logic    out_free;
    logic    ram_we;
    addr_t   ram_waddr;
    data_t   ram_wdata;
    addr_t   ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    state_t  dec_state;
    status_t dec_stat;
    addr_t   dec_pos;
    addr_t   dec_rd;
    addr_t   dec_lim;
    wide_t   pos_w;
    wide_t   cnt_w;
    logic    full;
    addr_t   cnt_a;
    addr_t   cnt_m1;
    logic    more;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign pos_w  = wide_t'(position);
    assign cnt_w  = wide_t'(count_reg);
    assign full   = (count_reg == cnt_t'(DEPTH));
    assign cnt_a  = count_reg[ADDR_W-1:0];
    assign cnt_m1 = addr_t'(count_reg - cnt_t'(1));
    assign more   = (wide_t'(pos_reg) + wide_t'(1)) < cnt_w;

    // request decode
    always_comb
    begin
        dec_state = S_DONE;
        dec_stat  = STAT_OK;
        dec_pos   = position[ADDR_W-1:0];
        dec_rd    = cnt_m1;
        dec_lim   = position[ADDR_W-1:0];
        case (action_t'(action))
            ACT_APPEND:
            begin
                if (full)
                begin
                    dec_stat = STAT_FULL;
                end
                else
                begin
                    dec_pos   = cnt_a;
                    dec_state = S_PUT;
                end
            end
            ACT_INSERT:
            begin
                if (pos_w > cnt_w)
                begin
                    dec_stat = STAT_RANGE;
                end
                else if (full)
                begin
                    dec_stat = STAT_FULL;
                end
                else if (pos_w == cnt_w)
                begin
                    dec_state = S_PUT;
                end
                else
                begin
                    dec_state = S_SHIFT_UP;
                end
            end
            ACT_REM_LAST:
            begin
                if (count_reg == cnt_t'(0))
                begin
                    dec_stat = STAT_RANGE;
                end
                else
                begin
                    dec_pos   = cnt_m1;
                    dec_state = S_TAKE;
                end
            end
            ACT_REM_AT, ACT_READ:
            begin
                if (pos_w >= cnt_w)
                begin
                    dec_stat = STAT_RANGE;
                end
                else
                begin
                    dec_state = S_TAKE;
                end
            end
            default:
            begin
                dec_stat = STAT_RANGE;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = dec_state;
                end
            end
            S_SHIFT_UP, S_SHIFT_DN:
            begin
                if (rd_reg == lim_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_TAKE:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (op_reg != ACT_READ && more)
                begin
                    state_next = S_SHIFT_DN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DRAIN:
            begin
                state_next = (op_reg == ACT_INSERT) ? S_PUT : S_DONE;
            end
            S_PUT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        op_next        = op_reg;
        pos_next       = pos_reg;
        rd_next        = rd_reg;
        lim_next       = lim_reg;
        val_next       = val_reg;
        rv_next        = rv_reg;
        stat_next      = stat_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        rv_out_next    = rv_out_reg;
        stat_out_next  = stat_out_reg;
        cnt_out_next   = cnt_out_reg;
        wpend_next     = (state_reg == S_SHIFT_UP) || (state_reg == S_SHIFT_DN);
        wpaddr_next    = (state_reg == S_SHIFT_UP) ? rd_reg + addr_t'(1) : rd_reg - addr_t'(1);
        ram_raddr      = (state_reg == S_TAKE) ? pos_reg : rd_reg;
        ram_we         = wpend_reg || (state_reg == S_PUT);
        ram_waddr      = wpend_reg ? wpaddr_reg : pos_reg;
        ram_wdata      = wpend_reg ? data_t'(ram_rdata) : val_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next   = action_t'(action);
                    pos_next  = dec_pos;
                    rd_next   = dec_rd;
                    lim_next  = dec_lim;
                    val_next  = value;
                    rv_next   = '0;
                    stat_next = dec_stat;
                end
            end
            S_SHIFT_UP:
            begin
                rd_next = rd_reg - addr_t'(1);
            end
            S_SHIFT_DN:
            begin
                rd_next = rd_reg + addr_t'(1);
            end
            S_LOAD:
            begin
                rv_next  = data_t'(ram_rdata);
                rd_next  = pos_reg + addr_t'(1);
                lim_next = cnt_m1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    if (stat_reg == STAT_OK)
                    begin
                        case (op_reg)
                            ACT_APPEND, ACT_INSERT:   count_next = count_reg + cnt_t'(1);
                            ACT_REM_LAST, ACT_REM_AT: count_next = count_reg - cnt_t'(1);
                            default:                  count_next = count_reg;
                        endcase
                    end
                    out_valid_next = 1'b1;
                    rv_out_next    = rv_reg;
                    stat_out_next  = stat_reg;
                    cnt_out_next   = count_next;
                end
            end
            default:
            begin
                op_next = op_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            wpend_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wpend_reg     <= wpend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        rd_reg       <= rd_next;
        lim_reg      <= lim_next;
        val_reg      <= val_next;
        rv_reg       <= rv_next;
        stat_reg     <= stat_next;
        wpaddr_reg   <= wpaddr_next;
        rv_out_reg   <= rv_out_next;
        stat_out_reg <= stat_out_next;
        cnt_out_reg  <= cnt_out_next;
    end

    ils_ram #(
        .AW (ADDR_W),
        .DW (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign read_value  = rv_out_reg;
    assign status      = stat_out_reg;
    assign count_after = wide_t'(cnt_out_reg);

    `ILS_NEVER(a_one_writer, wpend_reg && (state_reg == S_PUT))
    `ILS_NEVER(a_count_range, count_reg > cnt_t'(DEPTH))
    `ILS_IMPLY(a_count_moves_in_done, count_reg != $past(count_reg), $past(state_reg) == S_DONE)
    `ILS_NEXT(a_result_on_done, (state_reg == S_DONE) && out_free, out_valid_reg)

endmodule

@@ tb/sv/list_store_checker.sv @@
// Checker for the indexed list store: tracks the list, predicts each result and compares.
module list_store_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [ils_pkg::ACT_W-1:0]         action,
    input  logic [ils_pkg::POS_W-1:0]         position,
    input  logic signed [ils_pkg::DATA_W-1:0] value,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [ils_pkg::DATA_W-1:0] read_value,
    input  logic [ils_pkg::STAT_W-1:0]        status,
    input  logic [ils_pkg::COUNT_OUT_W-1:0]   count_after,
    output int                                fail_count,
    output int                                pending_count,
    output int                                result_count,
    output int                                full_refusals,
    output ils_pkg::wide_t                    list_length,
    output ils_pkg::wide_t                    peak_length
);

    import ils_pkg::*;

    typedef struct packed {
        data_t   read_value;
        status_t status;
        wide_t   count_after;
    } list_result_t;

    data_t        shadow_list [DEPTH];
    int           shadow_len = 0;
    int           longest = 0;
    int           mismatches = 0;
    int           compared = 0;
    int           refusals = 0;
    list_result_t expected_results [$];

    function automatic void check_field(input string field,
                                        input logic signed [63:0] expv,
                                        input logic signed [63:0] actv);
        if (actv !== expv)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, expv, actv);
        end
    endfunction

    task automatic apply_request(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                                 input data_t val);
        list_result_t r;
        int           p;
        int           i;
        p            = pos;
        r.read_value = '0;
        r.status     = STAT_OK;
        case (act)
            ACT_APPEND:
                if (shadow_len >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    shadow_list[shadow_len] = val;
                    shadow_len++;
                end
            ACT_INSERT:
                if (p > shadow_len)
                    r.status = STAT_RANGE;
                else if (shadow_len >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    for (i = shadow_len; i > p; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[p] = val;
                    shadow_len++;
                end
            ACT_REM_LAST:
                if (shadow_len == 0)
                    r.status = STAT_RANGE;
                else
                begin
                    r.read_value = shadow_list[shadow_len-1];
                    shadow_len--;
                end
            ACT_REM_AT:
                if (p >= shadow_len)
                    r.status = STAT_RANGE;
                else
                begin
                    r.read_value = shadow_list[p];
                    for (i = p; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            ACT_READ:
                if (p >= shadow_len)
                    r.status = STAT_RANGE;
                else
                    r.read_value = shadow_list[p];
            default:
                r.status = STAT_RANGE;
        endcase
        r.count_after = wide_t'(shadow_len);
        if (shadow_len > longest)
            longest = shadow_len;
        expected_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t exp_r;
        if (!rst_n)
        begin
            shadow_len = 0;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                compared++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, actual %0d / %0d / %0d",
                             $time, read_value, status, count_after);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.status == STAT_FULL)
                        refusals++;
                    check_field("read_value", 64'($signed(exp_r.read_value)),
                                64'(read_value));
                    check_field("status", 64'(exp_r.status), 64'(status));
                    check_field("count_after", 64'(exp_r.count_after), 64'(count_after));
                end
            end
            if (in_valid && !in_stall)
                apply_request(action, position, value);
        end
        fail_count    <= mismatches;
        pending_count <= expected_results.size();
        result_count  <= compared;
        full_refusals <= refusals;
        list_length   <= wide_t'(shadow_len);
        peak_length   <= wide_t'(longest);
    end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the indexed list store: clock, reset, request stimulus and verdict.
module tb;
    import ils_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_MID   = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;
    localparam int               RANDOM_ITEMS    = 700;
    localparam int               HOLD_OFF_CYCLES = 300;

    typedef enum int { MIX_GROW, MIX_EVEN, MIX_SHRINK } mix_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic [COUNT_OUT_W-1:0]   count_after;

    int    fail_count;
    int    pending_count;
    int    result_count;
    int    full_refusals;
    wide_t list_length;
    wide_t peak_length;

    logic  quiet;
    int    hold_offs_wanted;
    int    hold_offs_done;
    int    requests_sent;

    indexed_list_store i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .position    (position),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .status      (status),
        .count_after (count_after)
    );

    list_store_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .position      (position),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_value    (read_value),
        .status        (status),
        .count_after   (count_after),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count),
        .full_refusals (full_refusals),
        .list_length   (list_length),
        .peak_length   (peak_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20 * 500000);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        out_stall      <= 1'b0;
        hold_offs_done  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_offs_done != hold_offs_wanted)
            begin
                hold_offs_done++;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                                input data_t val);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        position <= pos;
        value    <= val;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    function automatic data_t pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return $urandom_range(0, 15);
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int top_pos;
        top_pos = list_length;
        case ($urandom_range(0, 9))
            0:       return POS_W'($urandom_range(0, (1 << POS_W) - 1));
            1:       return POS_W'(top_pos + $urandom_range(0, 1));
            default: return POS_W'($urandom_range(0, top_pos));
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] pick_action(input mix_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:
                if (roll < 35)      return ACT_APPEND;
                else if (roll < 70) return ACT_INSERT;
                else if (roll < 76) return ACT_REM_LAST;
                else if (roll < 82) return ACT_REM_AT;
                else if (roll < 97) return ACT_READ;
            MIX_SHRINK:
                if (roll < 8)       return ACT_APPEND;
                else if (roll < 16) return ACT_INSERT;
                else if (roll < 50) return ACT_REM_LAST;
                else if (roll < 84) return ACT_REM_AT;
                else if (roll < 97) return ACT_READ;
            default:
                if (roll < 22)      return ACT_APPEND;
                else if (roll < 44) return ACT_INSERT;
                else if (roll < 60) return ACT_REM_LAST;
                else if (roll < 76) return ACT_REM_AT;
                else if (roll < 97) return ACT_READ;
        endcase
        return ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    endfunction

    initial
    begin
        mix_t mix;
        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        action           <= ACT_APPEND;
        position         <= '0;
        value            <= '0;
        quiet            <= 1'b0;
        hold_offs_wanted <= 0;
        requests_sent     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(ACT_READ, 0, 0);
        send_request(ACT_REM_LAST, 0, 0);
        send_request(ACT_REM_AT, 0, 0);
        send_request(ACT_INSERT, 1, 5);
        send_request(ACT_INSERT, 0, 32'sh7FFF_FFFF);
        send_request(ACT_APPEND, 0, 32'sh8000_0000);
        send_request(ACT_INSERT, 2, -1);
        send_request(ACT_INSERT, 1, 32'sh5555_5555);
        send_request(ACT_READ, 0, 0);
        send_request(ACT_READ, 3, 0);
        send_request(ACT_READ, 4, 0);
        send_request(ACT_READ, 10'h3FF, 0);
        send_request(ACT_REM_AT, 10'h3FF, 0);
        send_request(ACT_SPARE_FIRST, 10'h3FF, -1);
        send_request(ACT_SPARE_MID, 1, 32'sh5555_5555);
        send_request(ACT_SPARE_LAST, 0, 0);
        send_request(ACT_REM_AT, 1, 0);
        send_request(ACT_REM_AT, 0, 0);
        send_request(ACT_REM_LAST, 0, 0);
        send_request(ACT_REM_LAST, 0, 0);
        send_request(ACT_REM_LAST, 0, 0);
        send_request(ACT_APPEND, 10'h3FF, 32'shAAAA_AAAA);
        send_request(ACT_REM_AT, 0, 0);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n < 150 || (n >= 400 && n < 550))
                mix = MIX_GROW;
            else if (n >= 250 && n < 400)
                mix = MIX_SHRINK;
            else
                mix = MIX_EVEN;
            if (n == 200)
                hold_offs_wanted <= hold_offs_wanted + 1;
            if (n == 350 || n == 500)
                drain_results();
            if (n == RANDOM_ITEMS - 100)
                quiet <= 1'b1;
            send_request(pick_action(mix), pick_position(), pick_value());
        end

        drain_results();
        repeat (DEPTH + 8) @(posedge clk);
        $display("Run covered %0d requests and %0d compared results, %0d refused on a full store.",
                 requests_sent, result_count, full_refusals);
        $display("Longest list held: %0d of %0d entries.", peak_length, DEPTH);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
